>>> sv/gtg_pkg.sv
`timescale 1ns / 1ps

package gtg_pkg;

   // Vectoring steps of the angle/distance chain (8 to 24).
   localparam int CORDIC_ITERATIONS = 16;

   // Restoring divider: one quotient bit per cell, 45-bit saturating quotient.
   localparam int DIV_STEPS = 45;
   localparam int DEN_W     = 39;   // |det| of the Q14 block
   localparam int NUM_W     = 54;   // adjugate row . offset
   localparam int LOW_W     = 31;   // numerator bits below the first remainder
   localparam int M_W       = 20;   // rounded Q14 matrix entry
   localparam int OFS_W     = 33;   // target minus robot
   localparam int CRD_W     = 48;   // robot-frame vector inside the chain
   localparam int ANG_W     = 34;   // Q30 angle
   localparam int ATAN_W    = 30;
   localparam int IDX_W     = 5;
   localparam int DIST_W    = 47;
   localparam int PROD_W    = 63;
   localparam int ZG_W      = 51;

   // Front end 4, divider, pre-rotation 1, vectoring, back end 3.
   localparam int LATENCY = 4 + DIV_STEPS + 1 + CORDIC_ITERATIONS + 3;

   localparam logic [DIV_STEPS-1:0]    FRAME_LIMIT = '1;
   localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic [15:0]             KINV_Q16    = 16'd39797;

   // Register indexes on the write port.
   localparam logic [2:0] REG_TARGET_X     = 3'd0;
   localparam logic [2:0] REG_TARGET_Y     = 3'd1;
   localparam logic [2:0] REG_ARRIVE_THR   = 3'd2;
   localparam logic [2:0] REG_HEADING_GAIN = 3'd3;
   localparam logic [2:0] REG_SPEED_GAIN   = 3'd4;

   // One lane of the divider: partial remainder, dividend bits still to
   // bring in (msb first), quotient so far, sign and overflow.
   typedef struct packed {
      logic [DEN_W-1:0]     rem;
      logic [DIV_STEPS-1:0] low;
      logic [DIV_STEPS-1:0] quo;
      logic                 neg;
      logic                 ovf;
   } div_lane_type;

   typedef struct packed {
      logic             singular;
      logic [DEN_W-1:0] den;
      div_lane_type     x;
      div_lane_type     y;
   } div_word_type;

   typedef struct packed {
      logic                    singular;
      logic signed [CRD_W-1:0] x;
      logic signed [CRD_W-1:0] y;
      logic signed [ANG_W-1:0] z;
   } crd_word_type;

   // Arctangent of 2^-i in Q30, truncated.
   function automatic logic [ATAN_W-1:0] atan_q30(input logic [IDX_W-1:0] i);
      logic [ATAN_W-1:0] v;
      case (i)
         5'd0:  v = 30'd843314856;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043836;
         5'd3:  v = 30'd133525158;
         5'd4:  v = 30'd67021686;
         5'd5:  v = 30'd33543515;
         5'd6:  v = 30'd16775850;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194282;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048575;
         5'd11: v = 30'd524287;
         5'd12: v = 30'd262143;
         5'd13: v = 30'd131071;
         5'd14: v = 30'd65535;
         5'd15: v = 30'd32767;
         5'd16: v = 30'd16383;
         5'd17: v = 30'd8191;
         5'd18: v = 30'd4095;
         5'd19: v = 30'd2047;
         5'd20: v = 30'd1023;
         5'd21: v = 30'd511;
         5'd22: v = 30'd255;
         5'd23: v = 30'd127;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> sv/gtg_div_cell.sv
`timescale 1ns / 1ps

module gtg_div_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   input  gtg_pkg::div_word_type up_word,
   output logic                dn_valid,
   output gtg_pkg::div_word_type dn_word
);
   import gtg_pkg::*;

   logic         valid_ff;
   div_word_type word_ff, word_in;

   // One restoring step: bring in the next dividend bit, subtract if it fits.
   function automatic div_lane_type div_step(input div_lane_type l,
                                              input logic [DEN_W-1:0] d);
      logic [DEN_W:0] trial;
      div_lane_type   r;
      trial = {l.rem, l.low[DIV_STEPS-1]};
      r     = l;
      r.low = {l.low[DIV_STEPS-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
         r.rem = DEN_W'(trial - {1'b0, d});
         r.quo = {l.quo[DIV_STEPS-2:0], 1'b1};
      end else begin
         r.rem = trial[DEN_W-1:0];
         r.quo = {l.quo[DIV_STEPS-2:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      word_in   = up_word;
      word_in.x = div_step(up_word.x, up_word.den);
      word_in.y = div_step(up_word.y, up_word.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule

>>> sv/gtg_cordic_cell.sv
`timescale 1ns / 1ps

module gtg_cordic_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [gtg_pkg::IDX_W-1:0] stage,
   input  logic                    up_valid,
   input  gtg_pkg::crd_word_type   up_word,
   output logic                    dn_valid,
   output gtg_pkg::crd_word_type   dn_word
);
   import gtg_pkg::*;

   logic                    valid_ff;
   crd_word_type            word_ff, word_in;
   logic signed [CRD_W-1:0] sx, sy;
   logic signed [ANG_W-1:0] step_ang;

   // Rotate toward the x axis by atan(2^-stage).
   always_comb begin
      sx       = up_word.x >>> stage;
      sy       = up_word.y >>> stage;
      step_ang = $signed({{(ANG_W-ATAN_W){1'b0}}, atan_q30(stage)});
      word_in  = up_word;
      if (up_word.y >= 0) begin
         word_in.x = up_word.x + sy;
         word_in.y = up_word.y - sx;
         word_in.z = up_word.z + step_ang;
      end else begin
         word_in.x = up_word.x - sy;
         word_in.y = up_word.y + sx;
         word_in.z = up_word.z - step_ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule

>>> sv/go_to_goal_velocity_command.sv
`timescale 1ns / 1ps
// Go-to-goal velocity command.
// Input channel: a pose word (req_robot_x/y in Q16.16, req_quat_w/x/y/z in
// Q1.14) is taken at a rising edge with start high and busy low. busy is
// always low: a new pose can be taken in every cycle.
// Result channel: one velocity word per pose, shown on the rsp_ ports for one
// cycle with rsp_valid high, in input order. The receiver cannot stall it.
// From the accepting edge to the result, each pose passes registered stages of
// matrix, determinant and numerator math and the divider load, 45 divider
// cells (one quotient bit each), one pre-rotation stage, 16 vectoring cells
// and three stages of gain and saturation. Throughput is one word per cycle;
// every stage and cell is registered, so no stage holds a word longer.
// Configuration: csr_we writes csr_wdata into register csr_index at the edge
// (target_x, target_y, arrive_threshold, heading_gain, speed_gain); write only
// while no result is outstanding. Unknown indexes are ignored.
// Reset (synchronous, active high) empties the pipeline, so no result from a
// pose taken before reset is shown, and loads the register defaults.
module go_to_goal_velocity_command (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_robot_x,
   input  logic signed [31:0] req_robot_y,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output logic               rsp_valid,
   output logic [30:0]        rsp_linear_speed,
   output logic signed [20:0] rsp_angular_speed,
   output logic               rsp_arrived,
   output logic               rsp_singular
);
   import gtg_pkg::*;

   // configuration registers
   logic signed [31:0] target_x_ff, target_y_ff;
   logic [30:0]        thresh_ff;
   logic [15:0]        hgain_ff, sgain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff <= '0;
         target_y_ff <= '0;
         thresh_ff   <= 31'd19661;
         hgain_ff    <= 16'd4506;
         sgain_ff    <= 16'd410;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TARGET_X:     target_x_ff <= csr_wdata;
            REG_TARGET_Y:     target_y_ff <= csr_wdata;
            REG_ARRIVE_THR:   thresh_ff   <= csr_wdata[30:0];
            REG_HEADING_GAIN: hgain_ff    <= csr_wdata[15:0];
            REG_SPEED_GAIN:   sgain_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 1: rotation block in Q14 and world-frame offset
   logic                    s1_valid_ff;
   logic signed [M_W-1:0]   m00_ff, m01_ff, m10_ff, m11_ff;
   logic signed [M_W-1:0]   m00_in, m01_in, m10_in, m11_in;
   logic signed [OFS_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [31:0]      p_xx, p_yy, p_zz, p_xy, p_wz;
   logic signed [35:0]      t00, t01, t10, t11;

   always_comb begin
      p_xx   = req_quat_x * req_quat_x;
      p_yy   = req_quat_y * req_quat_y;
      p_zz   = req_quat_z * req_quat_z;
      p_xy   = req_quat_x * req_quat_y;
      p_wz   = req_quat_w * req_quat_z;
      t00    = 36'sd268435456 - 36'sd2 * (36'(p_yy) + 36'(p_zz)) + 36'sd8192;
      t01    = 36'sd2 * (36'(p_xy) - 36'(p_wz)) + 36'sd8192;
      t10    = 36'sd2 * (36'(p_xy) + 36'(p_wz)) + 36'sd8192;
      t11    = 36'sd268435456 - 36'sd2 * (36'(p_xx) + 36'(p_zz)) + 36'sd8192;
      m00_in = t00[33:14];
      m01_in = t01[33:14];
      m10_in = t10[33:14];
      m11_in = t11[33:14];
      dx_in  = OFS_W'(target_x_ff) - OFS_W'(req_robot_x);
      dy_in  = OFS_W'(target_y_ff) - OFS_W'(req_robot_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      m00_ff <= m00_in;
      m01_ff <= m01_in;
      m10_ff <= m10_in;
      m11_ff <= m11_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
   end

   // stage 2: products for determinant and adjugate rows
   logic                    s2_valid_ff;
   logic signed [DEN_W:0]   pd_a_ff, pd_b_ff;
   logic signed [NUM_W-1:0] px_a_ff, px_b_ff, py_a_ff, py_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      pd_a_ff <= (DEN_W+1)'(m00_ff) * (DEN_W+1)'(m11_ff);
      pd_b_ff <= (DEN_W+1)'(m01_ff) * (DEN_W+1)'(m10_ff);
      px_a_ff <= NUM_W'(m11_ff) * NUM_W'(dx_ff);
      px_b_ff <= NUM_W'(m01_ff) * NUM_W'(dy_ff);
      py_a_ff <= NUM_W'(m00_ff) * NUM_W'(dy_ff);
      py_b_ff <= NUM_W'(m10_ff) * NUM_W'(dx_ff);
   end

   // stage 3: determinant and numerators
   logic                    s3_valid_ff;
   logic signed [DEN_W:0]   det_ff;
   logic signed [NUM_W-1:0] nx_ff, ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      det_ff <= pd_a_ff - pd_b_ff;
      nx_ff  <= px_a_ff - px_b_ff;
      ny_ff  <= py_a_ff - py_b_ff;
   end

   // stage 4: magnitudes, signs, overflow check, divider load
   logic                 s4_valid_ff;
   div_word_type         s4_word_ff, s4_word_in;
   logic [DEN_W:0]       ud_full;
   logic [DEN_W-1:0]     ud;
   logic [NUM_W-1:0]     unx, uny;
   logic [DEN_W+LOW_W:0] den_top;

   always_comb begin
      ud_full = det_ff[DEN_W] ? (DEN_W+1)'(-det_ff) : (DEN_W+1)'(det_ff);
      ud      = ud_full[DEN_W-1:0];
      unx     = nx_ff[NUM_W-1] ? NUM_W'(-nx_ff) : NUM_W'(nx_ff);
      uny     = ny_ff[NUM_W-1] ? NUM_W'(-ny_ff) : NUM_W'(ny_ff);
      den_top = {1'b0, ud, {LOW_W{1'b0}}};

      s4_word_in.singular = (det_ff == '0);
      s4_word_in.den      = ud;
      s4_word_in.x.rem    = DEN_W'(unx[NUM_W-1:LOW_W]);
      s4_word_in.x.low    = {unx[LOW_W-1:0], {(DIV_STEPS-LOW_W){1'b0}}};
      s4_word_in.x.quo    = '0;
      s4_word_in.x.neg    = nx_ff[NUM_W-1] ^ det_ff[DEN_W];
      s4_word_in.x.ovf    = ((DEN_W+LOW_W+1)'(unx) >= den_top);
      s4_word_in.y.rem    = DEN_W'(uny[NUM_W-1:LOW_W]);
      s4_word_in.y.low    = {uny[LOW_W-1:0], {(DIV_STEPS-LOW_W){1'b0}}};
      s4_word_in.y.quo    = '0;
      s4_word_in.y.neg    = ny_ff[NUM_W-1] ^ det_ff[DEN_W];
      s4_word_in.y.ovf    = ((DEN_W+LOW_W+1)'(uny) >= den_top);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_word_ff <= s4_word_in;
   end

   // divider chain: one quotient bit per cell
   logic         div_valid [DIV_STEPS+1];
   div_word_type div_word  [DIV_STEPS+1];

   assign div_valid[0] = s4_valid_ff;
   assign div_word[0]  = s4_word_ff;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      gtg_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (div_valid[k]),
         .up_word  (div_word[k]),
         .dn_valid (div_valid[k+1]),
         .dn_word  (div_word[k+1])
      );
   end

   // pre-rotation: signed quotients, half-turn when x is negative
   logic                    pr_valid_ff;
   crd_word_type            pr_word_ff, pr_word_in;
   logic [DIV_STEPS-1:0]    mx, my;
   logic signed [CRD_W-1:0] cx, cy;

   always_comb begin
      mx = div_word[DIV_STEPS].x.ovf ? FRAME_LIMIT : div_word[DIV_STEPS].x.quo;
      my = div_word[DIV_STEPS].y.ovf ? FRAME_LIMIT : div_word[DIV_STEPS].y.quo;
      cx = CRD_W'($signed({1'b0, mx}));
      cy = CRD_W'($signed({1'b0, my}));
      if (div_word[DIV_STEPS].x.neg) begin
         cx = -cx;
      end
      if (div_word[DIV_STEPS].y.neg) begin
         cy = -cy;
      end
      pr_word_in.singular = div_word[DIV_STEPS].singular;
      if (cx < 0) begin
         pr_word_in.x = -cx;
         pr_word_in.y = -cy;
         pr_word_in.z = (cy >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
         pr_word_in.x = cx;
         pr_word_in.y = cy;
         pr_word_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else begin
         pr_valid_ff <= div_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      pr_word_ff <= pr_word_in;
   end

   // vectoring chain
   logic         crd_valid [CORDIC_ITERATIONS+1];
   crd_word_type crd_word  [CORDIC_ITERATIONS+1];

   assign crd_valid[0] = pr_valid_ff;
   assign crd_word[0]  = pr_word_ff;

   for (genvar k = 0; k < CORDIC_ITERATIONS; k++) begin : g_crd
      gtg_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .stage    (IDX_W'(k)),
         .up_valid (crd_valid[k]),
         .up_word  (crd_word[k]),
         .dn_valid (crd_valid[k+1]),
         .dn_word  (crd_word[k+1])
      );
   end

   // back end 1: distance and scaled angle
   logic                   f1_valid_ff, f1_sing_ff;
   logic [DIST_W-1:0]      dist_ff;
   logic signed [ZG_W-1:0] zg_ff;
   logic [PROD_W-1:0]      dprod;

   always_comb begin
      dprod = {{(PROD_W-DIST_W){1'b0}}, crd_word[CORDIC_ITERATIONS].x[DIST_W-1:0]}
              * {{(PROD_W-16){1'b0}}, KINV_Q16} + PROD_W'(32768);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= crd_valid[CORDIC_ITERATIONS];
      end
   end

   always_ff @(posedge clock) begin
      f1_sing_ff <= crd_word[CORDIC_ITERATIONS].singular;
      dist_ff    <= dprod[PROD_W-1:16];
      zg_ff      <= ZG_W'(crd_word[CORDIC_ITERATIONS].z) * ZG_W'($signed({1'b0, hgain_ff}));
   end

   // back end 2: arrival, speed product, turn rate clamp
   logic               f2_valid_ff, f2_sing_ff, f2_arr_ff;
   logic [PROD_W-1:0]  lprod_ff;
   logic signed [20:0] ang_ff, ang_in;
   logic signed [21:0] ang_full;

   always_comb begin
      ang_full = zg_ff[ZG_W-1:29];
      if (ang_full > 22'sd1048575) begin
         ang_in = 21'sd1048575;
      end else if (ang_full < -22'sd1048576) begin
         ang_in = -21'sd1048576;
      end else begin
         ang_in = ang_full[20:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else begin
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f2_sing_ff <= f1_sing_ff;
      f2_arr_ff  <= (dist_ff < {{(DIST_W-31){1'b0}}, thresh_ff});
      lprod_ff   <= {{(PROD_W-DIST_W){1'b0}}, dist_ff} * {{(PROD_W-16){1'b0}}, sgain_ff};
      ang_ff     <= ang_in;
   end

   // back end 3: speed clamp and result select
   logic               rsp_valid_ff;
   logic [30:0]        lin_ff, lin_in, lin_sat;
   logic signed [20:0] angv_ff, angv_in;
   logic               arr_ff, arr_in, sing_ff, sing_in;

   always_comb begin
      lin_sat = (lprod_ff[PROD_W-1:43] != '0) ? 31'h7FFF_FFFF : lprod_ff[42:12];
      lin_in  = '0;
      angv_in = '0;
      arr_in  = 1'b0;
      sing_in = 1'b0;
      if (f2_sing_ff) begin
         sing_in = 1'b1;
      end else if (f2_arr_ff) begin
         arr_in = 1'b1;
      end else begin
         lin_in  = lin_sat;
         angv_in = ang_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      lin_ff  <= lin_in;
      angv_ff <= angv_in;
      arr_ff  <= arr_in;
      sing_ff <= sing_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_linear_speed  = lin_ff;
   assign rsp_angular_speed = angv_ff;
   assign rsp_arrived       = arr_ff;
   assign rsp_singular      = sing_ff;

endmodule

>>> sv/gtg_checker.sv
`timescale 1ns / 1ps

module gtg_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [30:0]        rsp_linear_speed,
   input logic signed [20:0] rsp_angular_speed,
   input logic               rsp_arrived,
   input logic               rsp_singular
);
   import gtg_pkg::*;

   // reset empties the pipeline
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word right after reset");

   // every accepted pose comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result word missing at expected latency");

   // singular block gives zero speeds and no arrival
   a_singular: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |->
         (rsp_linear_speed == '0 && rsp_angular_speed == '0 && !rsp_arrived))
      else $error("singular word with nonzero command");

   // arrival gives zero speeds
   a_arrived: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_arrived) |->
         (rsp_linear_speed == '0 && rsp_angular_speed == '0 && !rsp_singular))
      else $error("arrival word with nonzero command");

endmodule

bind go_to_goal_velocity_command gtg_checker u_gtg_checker (.*);

>>> bench/go_to_goal_velocity_command_tb.sv
`timescale 1ns / 1ps

module go_to_goal_velocity_command_tb;
   import gtg_pkg::*;

   localparam int         IDLE_LIMIT = 1000;
   localparam int         RANDOM_PER_PHASE = 120;
   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam longint     FRAME_MAX = 64'sd35184372088831;
   localparam longint     PI_ANGLE = 64'sd3373259426;

   typedef struct packed {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [15:0] qw;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
   } pose_type;

   typedef struct packed {
      logic [30:0]        lin;
      logic signed [20:0] ang;
      logic               arrived;
      logic               singular;
   } velocity_type;

   typedef struct packed {
      pose_type     pose;
      logic         typed;
      velocity_type want;
   } pose_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_robot_x = '0;
   logic signed [31:0] req_robot_y = '0;
   logic signed [15:0] req_quat_w = '0;
   logic signed [15:0] req_quat_x = '0;
   logic signed [15:0] req_quat_y = '0;
   logic signed [15:0] req_quat_z = '0;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;
   logic               rsp_valid;
   logic [30:0]        rsp_linear_speed;
   logic signed [20:0] rsp_angular_speed;
   logic               rsp_arrived;
   logic               rsp_singular;

   // shadow copy of the command registers
   longint          goal_x, goal_y;
   longint unsigned arrive_thr, turn_gain, fwd_gain;

   velocity_type pending_cmds[$];
   int           mismatches = 0;
   int           idle_cycles = 0;

   longint atan_lut[24] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767, 16383, 8191,
      4095, 2047, 1023, 511, 255, 127};

   go_to_goal_velocity_command DUT (.*);

   always #4 clock = ~clock;

   // num * 2^14 / den, toward zero, clamped to the frame range
   function automatic longint frame_ratio(longint num, longint den);
      longint unsigned un, ud, q, m;
      logic            neg;
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      neg = (num < 0) != (den < 0);
      q = un / ud;
      if (q >= (64'd1 << 31)) begin
         m = FRAME_MAX;
      end else begin
         m = (q << 14) + (((un % ud) << 14) / ud);
         if (m > FRAME_MAX) m = FRAME_MAX;
      end
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic velocity_type predict_velocity(pose_type p);
      longint          qw, qx, qy, qz, m00, m01, m10, m11, det;
      longint          dx, dy, cx, cy, z, ang, sx, sy;
      longint unsigned span, lin;
      velocity_type    v;
      qw = p.qw; qx = p.qx; qy = p.qy; qz = p.qz;
      v = '0;
      // rounded Q14 rotation block and its determinant
      m00 = ((64'sd1 << 28) - 2 * (qy * qy + qz * qz) + 8192) >>> 14;
      m01 = (2 * (qx * qy - qw * qz) + 8192) >>> 14;
      m10 = (2 * (qx * qy + qw * qz) + 8192) >>> 14;
      m11 = ((64'sd1 << 28) - 2 * (qx * qx + qz * qz) + 8192) >>> 14;
      det = m00 * m11 - m01 * m10;
      if (det == 0) begin
         v.singular = 1'b1;
         return v;
      end
      // offset into robot frame
      dx = goal_x - longint'(p.rx);
      dy = goal_y - longint'(p.ry);
      cx = frame_ratio(m11 * dx - m01 * dy, det);
      cy = frame_ratio(m00 * dy - m10 * dx, det);
      // vectoring with pi pre-rotation for the left half plane
      z = 0;
      if (cx < 0) begin
         z = (cy >= 0) ? PI_ANGLE : -PI_ANGLE;
         cx = -cx;
         cy = -cy;
      end
      for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
         sx = cx >>> i;
         sy = cy >>> i;
         if (cy >= 0) begin
            cx += sy; cy -= sx; z += atan_lut[i];
         end else begin
            cx -= sy; cy += sx; z -= atan_lut[i];
         end
      end
      span = (longint'(cx) * 39797 + 32768) >> 16;
      if (span < arrive_thr) begin
         v.arrived = 1'b1;
         return v;
      end
      lin = (span * fwd_gain) >> 12;
      if (lin > 64'h7FFFFFFF) lin = 64'h7FFFFFFF;
      ang = (z * longint'(turn_gain)) >>> 29;
      if (ang > 1048575) ang = 1048575;
      if (ang < -1048576) ang = -1048576;
      v.lin = lin[30:0];
      v.ang = ang[20:0];
      return v;
   endfunction

   // one register write; called at a rising edge, leaves csr_we high
   task automatic write_reg(logic [2:0] idx, logic [31:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_TARGET_X:     goal_x = longint'(signed'(data));
         REG_TARGET_Y:     goal_y = longint'(signed'(data));
         REG_ARRIVE_THR:   arrive_thr = data[30:0];
         REG_HEADING_GAIN: turn_gain = data[15:0];
         REG_SPEED_GAIN:   fwd_gain = data[15:0];
         default: ;
      endcase
   endtask

   // present one pose word and hold it until taken; ends on the accepting edge
   task automatic send_pose(pose_type p, logic typed, velocity_type want);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_robot_x <= p.rx;
      req_robot_y <= p.ry;
      req_quat_w <= p.qw;
      req_quat_x <= p.qx;
      req_quat_y <= p.qy;
      req_quat_z <= p.qz;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_cmds.push_back(typed ? want : predict_velocity(p));
   endtask

   function automatic pose_type random_pose();
      pose_type    p;
      int unsigned kind;
      int          reach;
      kind = $urandom_range(0, 9);
      p.rx = $urandom;
      p.ry = $urandom;
      p.qw = $urandom;
      p.qx = $urandom;
      p.qy = $urandom;
      p.qz = $urandom;
      if (kind == 1) begin
         // degenerate block: zero first row
         p.qy = $urandom_range(0, 1) ? 16'sd8192 : -16'sd8192;
         p.qz = $urandom_range(0, 1) ? 16'sd8192 : -16'sd8192;
         p.qx = '0;
         p.qw = '0;
      end else if (kind >= 2) begin
         // yaw-dominated pose near the goal
         p.qw = $urandom_range(0, 32768) - 16384;
         p.qz = $urandom_range(0, 32768) - 16384;
         p.qx = $urandom_range(0, 2048) - 1024;
         p.qy = $urandom_range(0, 2048) - 1024;
         reach = (kind < 5) ? (1 << 16) : (16 << 16);
         p.rx = 32'(goal_x + $urandom_range(0, 2 * reach) - reach);
         p.ry = 32'(goal_y + $urandom_range(0, 2 * reach) - reach);
      end
      return p;
   endfunction

   // wait for the pipe to drain, then write a register set
   task automatic set_phase(logic [31:0] tx, logic [31:0] ty, logic [31:0] thr,
                            logic [31:0] hg, logic [31:0] sg);
      start <= 1'b0;
      wait (pending_cmds.size() == 0);
      @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      write_reg(REG_TARGET_X, tx);
      write_reg(REG_TARGET_Y, ty);
      write_reg(REG_ARRIVE_THR, thr);
      write_reg(REG_HEADING_GAIN, hg);
      write_reg(REG_SPEED_GAIN, sg);
      write_reg(REG_UNUSED, $urandom);
      csr_we <= 1'b0;
   endtask

   task automatic random_burst(int count);
      for (int n = 0; n < count; n++) send_pose(random_pose(), 1'b0, '0);
   endtask

   // result checker
   always @(posedge clock) begin
      velocity_type want;
      if (!reset && rsp_valid) begin
         if (pending_cmds.size() == 0) begin
            $error("unexpected velocity word");
            mismatches++;
         end else begin
            want = pending_cmds.pop_front();
            if (rsp_linear_speed !== want.lin) begin
               $error("linear_speed exp %0d got %0d", want.lin, rsp_linear_speed);
               mismatches++;
            end
            if (rsp_angular_speed !== want.ang) begin
               $error("angular_speed exp %0d got %0d", want.ang, rsp_angular_speed);
               mismatches++;
            end
            if (rsp_arrived !== want.arrived) begin
               $error("arrived exp %0d got %0d", want.arrived, rsp_arrived);
               mismatches++;
            end
            if (rsp_singular !== want.singular) begin
               $error("singular exp %0d got %0d", want.singular, rsp_singular);
               mismatches++;
            end
         end
      end
   end

   // watchdog on progress
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("go_to_goal_velocity_command: mismatch");
            $finish;
         end
      end
   end

   initial begin
      pose_row_type rows[13];
      goal_x = 0;
      goal_y = 0;
      arrive_thr = 19661;
      turn_gain = 4506;
      fwd_gain = 410;
      // pose: x, y, qw, qx, qy, qz | typed | lin, ang, arrived, singular
      rows = '{
         // sitting on the goal after reset
         '{'{32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
           '{31'd0, 21'sd0, 1'b1, 1'b0}},
         // zero determinant
         '{'{32'sd1000, 32'sd0, 16'sd0, 16'sd0, 16'sd8192, 16'sd8192}, 1'b1,
           '{31'd0, 21'sd0, 1'b0, 1'b1}},
         // nearly singular, frame clamps
         '{'{32'sd70000, -32'sd5, 16'sd0, 16'sd1, 16'sd8192, 16'sd8192}, 1'b0, '0},
         '{'{32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
         '{'{-32'sd327680, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
         '{'{32'sd327680, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
         '{'{32'sd327680, -32'sd65536, 16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
         '{'{32'sd0, 32'sd200000, 16'sd11585, 16'sd0, 16'sd0, 16'sd11585}, 1'b0, '0},
         '{'{32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
           1'b0, '0},
         '{'{32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
           1'b0, '0},
         '{'{32'h80000000, 32'h7FFFFFFF, 16'h7FFF, 16'h8000, 16'h0, 16'h7FFF},
           1'b0, '0},
         '{'{32'h7FFFFFFF, 32'h80000000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0},
           1'b0, '0},
         '{'{32'sd10000, 32'sd10000, 16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_pose(rows[i].pose, rows[i].typed, rows[i].want);
      random_burst(RANDOM_PER_PHASE);

      // far targets, zero arrival threshold (no arrival), full gains: saturation
      set_phase(32'h7FFFFFFF, 32'h80000000, 32'd0, 32'hFFFF, 32'hFFFF);
      foreach (rows[i]) send_pose(rows[i].pose, 1'b0, '0);
      random_burst(RANDOM_PER_PHASE);

      // maximum arrival threshold, so poses near the goal arrive, zero gains
      set_phase(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd0, 32'd0);
      random_burst(RANDOM_PER_PHASE);

      set_phase($urandom_range(0, 32'h00FFFFFF) - 32'h007FFFFF,
                $urandom_range(0, 32'h00FFFFFF) - 32'h007FFFFF,
                32'd19661, 32'd4506, 32'd410);
      random_burst(RANDOM_PER_PHASE);

      set_phase($urandom, $urandom, $urandom_range(0, 32'h0003FFFF),
                $urandom, $urandom);
      random_burst(RANDOM_PER_PHASE);

      // drain
      start <= 1'b0;
      wait (pending_cmds.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0) begin
         $display("go_to_goal_velocity_command: match");
      end else begin
         $display("go_to_goal_velocity_command: mismatch");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/gtg_pkg.sv
sv/gtg_div_cell.sv
sv/gtg_cordic_cell.sv
sv/go_to_goal_velocity_command.sv
sv/gtg_checker.sv
bench/go_to_goal_velocity_command_tb.sv
